// ===== sv/fcc_pkg.sv =====
`default_nettype none

package fcc_pkg;

    // Field widths and stream packing
    localparam int IN_W        = 10;
    localparam int CENT_W      = 13;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    // Output universe breakpoints
    localparam int OUT_B1   = 760;
    localparam int OUT_B2   = 1520;
    localparam int OUT_B3   = 2280;
    localparam int OUT_B4   = 3040;
    localparam int OUT_B5   = 3800;
    localparam int OUT_LAST = 4560;

    // Input fuzzy sets, walked one per divide
    typedef enum logic [2:0] {
        SET_CHEAP = 3'd0,
        SET_NEAR  = 3'd1,
        SET_MID   = 3'd2,
        SET_HOT   = 3'd3,
        SET_FAR   = 3'd4
    } set_idx_t;

    // Shape of a membership at the current input
    typedef enum logic [1:0] {
        MK_ZERO = 2'd0,
        MK_FULL = 2'd1,
        MK_RAMP = 2'd2
    } mem_kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_FUZZ_START = 4'd1,
        ST_FUZZ_WAIT  = 4'd2,
        ST_SWEEP_INIT = 4'd3,
        ST_SWEEP      = 4'd4,
        ST_DRAIN      = 4'd5,
        ST_DIV_START  = 4'd6,
        ST_DIV_WAIT   = 4'd7,
        ST_OUT        = 4'd8
    } fcc_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic     load_in;
        logic     div_start;
        logic     div_centroid;
        set_idx_t set_idx;
        logic     mem_store;
        logic     sweep_init;
        logic     sweep_step;
        logic     out_load;
    } fcc_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic div_done;
        logic last_point;
        logic pipe_busy;
        logic area_zero;
        logic out_busy;
    } fcc_status_t;

endpackage

`default_nettype wire

// ===== sv/fcc_div.sv =====
`default_nettype none

module fcc_div #(
    parameter int NW = 41,
    parameter int AW = 29,
    parameter int QB = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [AW-1:0] den,
    output logic               done,
    output logic [QB-1:0]      quo
);
    import fcc_pkg::*;

    localparam int DW   = AW + QB - 1;
    localparam int CW   = (NW > DW) ? NW : DW;
    localparam int CNTW = $clog2(QB + 1);

    logic [NW-1:0]   rem_reg;
    logic [DW-1:0]   dsh_reg;
    logic [QB-1:0]   quo_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [CW-1:0]   rem_ext;
    logic [CW-1:0]   dsh_ext;
    logic [CW-1:0]   diff;
    logic            ge;

    // Trial subtract of the shifted divisor
    always_comb begin
        rem_ext = CW'(rem_reg);
        dsh_ext = CW'(dsh_reg);
        diff    = rem_ext - dsh_ext;
        ge      = (rem_ext >= dsh_ext);
    end

    // Control: count quotient bits, pulse done at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one quotient bit per cycle, most significant first
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= DW'(den) << (QB - 1);
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= NW'(diff);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QB-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== sv/fcc_datapath.sv =====
`default_nettype none

module fcc_datapath #(
    parameter int MEMBERSHIP_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [fcc_pkg::IN_W-1:0]    temperature,
    input  wire logic [fcc_pkg::IN_W-1:0]    distance,
    input  wire fcc_pkg::fcc_cmd_t           cmd,
    output fcc_pkg::fcc_status_t             status,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output logic [fcc_pkg::CENT_W-1:0]       centroid,
    output logic                             no_rule_fired
);
    import fcc_pkg::*;

    localparam int MB    = MEMBERSHIP_BITS;
    localparam int W     = MB + 1;
    localparam int AW    = MB + 13;
    localparam int MW    = MB + 25;
    localparam int PW    = CENT_W + W;
    localparam int QB    = (W > CENT_W) ? W : CENT_W;
    localparam int QSTEP = (1 << MB) / OUT_B1;
    localparam int RSTEP = (1 << MB) % OUT_B1;
    localparam logic [W-1:0] FULL = {1'b1, {MB{1'b0}}};

    // Input latch and rule strengths
    logic [IN_W-1:0] temp_reg;
    logic [IN_W-1:0] dist_reg;
    logic [W-1:0]    r1_reg;
    logic [W-1:0]    r2_reg;
    logic [W-1:0]    r3_reg;

    // Sweep state
    logic [CENT_W-1:0] x_reg;
    logic [9:0]        k_reg;
    logic              up_reg;
    logic [1:0]        seg_reg;
    logic [W-1:0]      q_reg;
    logic [9:0]        rr_reg;

    // Accumulation pipeline
    logic              v1_reg;
    logic              v2_reg;
    logic [W-1:0]      w1_reg;
    logic [CENT_W-1:0] x1_reg;
    logic [PW-1:0]     prod_reg;
    logic [AW-1:0]     area_reg;
    logic [MW-1:0]     moment_reg;

    // Result register
    logic              m_valid_reg;
    logic [CENT_W-1:0] centroid_reg;
    logic              flag_reg;

    // Divider hookup
    logic [MW-1:0]     div_num;
    logic [AW-1:0]     div_den;
    logic              div_done;
    logic [QB-1:0]     div_quo;

    // Membership numerator and denominator
    mem_kind_t         mkind;
    logic [IN_W-1:0]   mx;
    logic [IN_W-1:0]   dk;
    logic [7:0]        mden;
    logic [MW-1:0]     num_mem;
    logic [AW-1:0]     den_mem;
    logic [W-1:0]      mem_q;

    // Sweep next values
    logic [10:0]       rr_up;
    logic              carry_up;
    logic              borrow;
    logic [W-1:0]      q_inc;
    logic [W-1:0]      q_dec;
    logic [9:0]        rr_inc;
    logic [9:0]        rr_dec;
    logic [W-1:0]      q_next;
    logic [9:0]        rr_next;
    logic [9:0]        k_next;
    logic              up_next;
    logic [1:0]        seg_next;
    logic [W-1:0]      rsel;
    logic [W-1:0]      wcur;

    // Pick the ramp of the selected input set
    always_comb begin
        mx    = (cmd.set_idx == SET_NEAR || cmd.set_idx == SET_FAR) ? dist_reg : temp_reg;
        mkind = MK_ZERO;
        dk    = '0;
        mden  = 8'd1;
        case (cmd.set_idx)
            SET_CHEAP: begin
                if (mx <= 10'd352) begin
                    mkind = MK_ZERO;
                end else if (mx <= 10'd368) begin
                    mkind = MK_RAMP; dk = mx - 10'd352; mden = 8'd16;
                end else if (mx <= 10'd384) begin
                    mkind = MK_FULL;
                end else if (mx < 10'd432) begin
                    mkind = MK_RAMP; dk = 10'd432 - mx; mden = 8'd48;
                end
            end
            SET_NEAR: begin
                if (mx <= 10'd80) begin
                    mkind = MK_FULL;
                end else if (mx < 10'd240) begin
                    mkind = MK_RAMP; dk = 10'd240 - mx; mden = 8'd160;
                end
            end
            SET_MID: begin
                if (mx <= 10'd384) begin
                    mkind = MK_ZERO;
                end else if (mx <= 10'd448) begin
                    mkind = MK_RAMP; dk = mx - 10'd384; mden = 8'd64;
                end else if (mx < 10'd512) begin
                    mkind = MK_RAMP; dk = 10'd512 - mx; mden = 8'd64;
                end
            end
            SET_HOT: begin
                if (mx <= 10'd464) begin
                    mkind = MK_ZERO;
                end else if (mx <= 10'd512) begin
                    mkind = MK_RAMP; dk = mx - 10'd464; mden = 8'd48;
                end else if (mx <= 10'd528) begin
                    mkind = MK_FULL;
                end else if (mx < 10'd544) begin
                    mkind = MK_RAMP; dk = 10'd544 - mx; mden = 8'd16;
                end
            end
            SET_FAR: begin
                if (mx <= 10'd560) begin
                    mkind = MK_ZERO;
                end else if (mx <= 10'd720) begin
                    mkind = MK_RAMP; dk = mx - 10'd560; mden = 8'd160;
                end else if (mx <= 10'd800) begin
                    mkind = MK_FULL;
                end else if (mx < 10'd816) begin
                    mkind = MK_RAMP; dk = 10'd816 - mx; mden = 8'd16;
                end
            end
            default: begin
                mkind = MK_ZERO;
            end
        endcase
        case (mkind)
            MK_RAMP: begin
                num_mem = MW'(dk[7:0]) << MB;
                den_mem = AW'(mden);
            end
            MK_FULL: begin
                num_mem = MW'(FULL);
                den_mem = AW'(1);
            end
            default: begin
                num_mem = '0;
                den_mem = AW'(1);
            end
        endcase
    end

    // Share one divider between memberships and the centroid
    assign div_num = cmd.div_centroid ? moment_reg : num_mem;
    assign div_den = cmd.div_centroid ? area_reg : den_mem;
    assign mem_q   = div_quo[W-1:0];

    fcc_div #(
        .NW (MW),
        .AW (AW),
        .QB (QB)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Latch inputs and fold memberships into rule strengths
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            temp_reg <= temperature;
            dist_reg <= distance;
            r1_reg   <= '0;
            r2_reg   <= '0;
            r3_reg   <= '0;
        end else if (cmd.mem_store) begin
            case (cmd.set_idx)
                SET_CHEAP, SET_NEAR: begin
                    if (mem_q > r1_reg) r1_reg <= mem_q;
                end
                SET_MID: begin
                    r2_reg <= mem_q;
                end
                SET_HOT, SET_FAR: begin
                    if (mem_q > r3_reg) r3_reg <= mem_q;
                end
                default: begin
                    r1_reg <= r1_reg;
                end
            endcase
        end
    end

    // Track k*S/760 as quotient and remainder, stepping up or down by one
    always_comb begin
        rr_up    = 11'(rr_reg) + 11'(RSTEP);
        carry_up = (rr_up >= 11'(OUT_B1));
        q_inc    = q_reg + W'(QSTEP) + W'(carry_up);
        rr_inc   = carry_up ? 10'(rr_up - 11'(OUT_B1)) : rr_up[9:0];
        borrow   = (rr_reg < 10'(RSTEP));
        q_dec    = q_reg - W'(QSTEP) - W'(borrow);
        rr_dec   = borrow ? 10'(11'(rr_reg) + 11'(OUT_B1) - 11'(RSTEP))
                          : 10'(rr_reg - 10'(RSTEP));
        q_next   = q_inc;
        rr_next  = rr_inc;
        k_next   = k_reg + 10'd1;
        up_next  = up_reg;
        seg_next = seg_reg;
        if (up_reg) begin
            if (k_reg == 10'(OUT_B1)) begin
                q_next  = q_dec;
                rr_next = rr_dec;
                k_next  = k_reg - 10'd1;
                up_next = 1'b0;
            end
        end else begin
            if (k_reg == 10'd0) begin
                up_next  = 1'b1;
                seg_next = seg_reg + 2'd1;
            end else begin
                q_next  = q_dec;
                rr_next = rr_dec;
                k_next  = k_reg - 10'd1;
            end
        end
        case (seg_reg)
            2'd0:    rsel = r1_reg;
            2'd1:    rsel = r2_reg;
            2'd2:    rsel = r3_reg;
            default: rsel = '0;
        endcase
        wcur = (q_reg < rsel) ? q_reg : rsel;
    end

    // Advance the output point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            k_reg   <= '0;
            up_reg  <= 1'b1;
            seg_reg <= '0;
            q_reg   <= '0;
            rr_reg  <= '0;
        end else if (cmd.sweep_init) begin
            x_reg   <= '0;
            k_reg   <= '0;
            up_reg  <= 1'b1;
            seg_reg <= '0;
            q_reg   <= '0;
            rr_reg  <= '0;
        end else if (cmd.sweep_step) begin
            x_reg   <= x_reg + 1'b1;
            k_reg   <= k_next;
            up_reg  <= up_next;
            seg_reg <= seg_next;
            q_reg   <= q_next;
            rr_reg  <= rr_next;
        end
    end

    // Pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.sweep_step;
            v2_reg <= v1_reg;
        end
    end

    // Clip, weigh by position, accumulate area and moment
    always_ff @(posedge aclk) begin
        w1_reg   <= wcur;
        x1_reg   <= x_reg;
        prod_reg <= PW'(x1_reg) * PW'(w1_reg);
        if (cmd.sweep_init) begin
            area_reg   <= '0;
            moment_reg <= '0;
        end else begin
            if (v1_reg) area_reg <= area_reg + AW'(w1_reg);
            if (v2_reg) moment_reg <= moment_reg + MW'(prod_reg);
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            flag_reg     <= status.area_zero;
            centroid_reg <= status.area_zero ? '0 : div_quo[CENT_W-1:0];
        end
    end

    assign status.div_done   = div_done;
    assign status.last_point = (x_reg == CENT_W'(OUT_LAST));
    assign status.pipe_busy  = v1_reg | v2_reg;
    assign status.area_zero  = (area_reg == '0);
    assign status.out_busy   = m_valid_reg & ~m_ready;

    assign m_valid       = m_valid_reg;
    assign centroid      = centroid_reg;
    assign no_rule_fired = flag_reg;

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && flag_reg |-> centroid_reg == '0)
        else $error("centroid not zero with no rule fired");

    a_cent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> centroid_reg <= CENT_W'(OUT_LAST))
        else $error("centroid beyond output range");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rr_reg < 10'(OUT_B1))
        else $error("sweep remainder out of range");

    a_mu_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_reg <= FULL)
        else $error("output membership above full scale");

endmodule

`default_nettype wire

// ===== sv/fcc_ctrl.sv =====
`default_nettype none

module fcc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire fcc_pkg::fcc_status_t status,
    output fcc_pkg::fcc_cmd_t         cmd
);
    import fcc_pkg::*;

    fcc_state_t state_reg;
    fcc_state_t state_next;
    set_idx_t   set_reg;
    set_idx_t   set_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            set_reg   <= SET_CHEAP;
        end else begin
            state_reg <= state_next;
            set_reg   <= set_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        set_next         = set_reg;
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.set_idx      = set_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    set_next    = SET_CHEAP;
                    state_next  = ST_FUZZ_START;
                end
            end
            ST_FUZZ_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_FUZZ_WAIT;
            end
            ST_FUZZ_WAIT: begin
                if (status.div_done) begin
                    cmd.mem_store = 1'b1;
                    case (set_reg)
                        SET_CHEAP: set_next = SET_NEAR;
                        SET_NEAR:  set_next = SET_MID;
                        SET_MID:   set_next = SET_HOT;
                        SET_HOT:   set_next = SET_FAR;
                        default:   set_next = SET_CHEAP;
                    endcase
                    state_next = (set_reg == SET_FAR) ? ST_SWEEP_INIT : ST_FUZZ_START;
                end
            end
            ST_SWEEP_INIT: begin
                cmd.sweep_init = 1'b1;
                state_next     = ST_SWEEP;
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.last_point) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = status.area_zero ? ST_OUT : ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                cmd.div_centroid = 1'b1;
                cmd.div_start    = 1'b1;
                state_next       = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                cmd.div_centroid = 1'b1;
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.div_centroid = 1'b1;
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/fuzzy_centroid_controller_core.sv =====
`default_nettype none

// Fuzzy centroid controller: takes one item of temperature and distance (unsigned, 1/16 units),
// evaluates the three rules and returns floor(moment / area) of the clipped output triangles,
// with no_rule_fired set and centroid 0 when no rule has any strength. One item is in work at
// a time: five membership divides and, when the area is not zero, the centroid divide run one
// quotient bit per cycle on a shared divider, and the sweep over the 4561 output points takes
// one point per cycle. A finished result waits in an output register while the next item is
// taken.
module fuzzy_centroid_controller_core #(
    parameter int MEMBERSHIP_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [9:0] temperature, [19:10] distance, [23:20] zero
    input  wire logic [fcc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [12:0] centroid, [15:13] zero
    output logic [fcc_pkg::M_TDATA_W-1:0]        m_tdata,
    // [0] no_rule_fired
    output logic [0:0]                           m_tuser
);
    import fcc_pkg::*;

    fcc_cmd_t          cmd;
    fcc_status_t       status;
    logic [CENT_W-1:0] centroid;
    logic              no_rule_fired;

    fcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    fcc_datapath #(
        .MEMBERSHIP_BITS (MEMBERSHIP_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .temperature   (s_tdata[IN_W-1:0]),
        .distance      (s_tdata[2*IN_W-1:IN_W]),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_tready),
        .m_valid       (m_tvalid),
        .centroid      (centroid),
        .no_rule_fired (no_rule_fired)
    );

    // Pack the result item
    assign m_tdata = {{(M_TDATA_W - CENT_W){1'b0}}, centroid};
    assign m_tuser = no_rule_fired;

endmodule

`default_nettype wire
